// ===== rtl/core/sorb_pkg.sv =====
// Shared types and constants for the sequence reorder buffer.
`default_nettype none

package sorb_pkg;

    localparam int IDX_W      = 32;
    localparam int DESC_W     = 32;
    localparam int AGE_W      = 8;
    localparam int CFG_W      = 6;
    localparam int KIND_W     = 3;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    localparam logic [1:0] REG_DEPTH_LIMIT    = 2'd0;
    localparam logic [1:0] REG_WAIT_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_RELEASE_ENABLE = 2'd2;

    localparam logic [CFG_W-1:0] DEPTH_LIMIT_RST    = 6'd32;
    localparam logic [CFG_W-1:0] WAIT_THRESHOLD_RST = 6'd32;

    localparam logic [KIND_W-1:0] KIND_IN_ORDER = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GAP_SKIP = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STALE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EVICT    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FLUSH    = 3'd4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef struct packed {
        logic [DESC_W-1:0] descriptor;
        logic [IDX_W-1:0]  index;
    } entry_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  index;
        logic [DESC_W-1:0] descriptor;
        logic [IDX_W-1:0]  expected_after;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] depth_limit;
        logic [CFG_W-1:0] wait_threshold;
        logic             release_enable;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND_START,
        ST_FIND_WAIT,
        ST_DECIDE,
        ST_EMIT,
        ST_INSERT,
        ST_FINAL
    } state_t;

    typedef enum logic [1:0] {
        MODE_EVICT,
        MODE_RELEASE,
        MODE_FLUSH
    } mode_t;

endpackage

`default_nettype wire

// ===== rtl/core/sorb_store.sv =====
// Entry memory with valid bits, ages and free-slot encoder.
`default_nettype none

module sorb_store #(
    parameter int DEPTH = 32,
    localparam int SLOT_W = $clog2(DEPTH)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [SLOT_W-1:0]             rd_addr,
    output sorb_pkg::entry_t                   rd_entry,
    output logic                               rd_valid,
    output logic [sorb_pkg::AGE_W-1:0]         rd_age,
    input  wire logic                          ins_en,
    input  wire logic [SLOT_W-1:0]             ins_slot,
    input  wire sorb_pkg::entry_t              ins_entry,
    input  wire logic                          clr_en,
    input  wire logic [SLOT_W-1:0]             clr_slot,
    output logic [SLOT_W-1:0]                  free_slot
);

    sorb_pkg::entry_t                  mem [DEPTH];
    sorb_pkg::entry_t                  rd_entry_reg;
    logic                              rd_valid_reg;
    logic [sorb_pkg::AGE_W-1:0]        rd_age_reg;
    logic [DEPTH-1:0]                  valid_reg;
    logic [DEPTH-1:0]                  valid_next;
    logic [sorb_pkg::AGE_W-1:0]        age_reg  [DEPTH];
    logic [sorb_pkg::AGE_W-1:0]        age_next [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ins_en)
        begin
            mem[ins_slot] <= ins_entry;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            age_next[i] = age_reg[i];
        end
        if (ins_en)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (valid_reg[i] && (age_reg[i] != sorb_pkg::AGE_MAX))
                begin
                    age_next[i] = age_reg[i] + 1'b1;
                end
            end
            valid_next[ins_slot] = 1'b1;
            age_next[ins_slot]   = '0;
        end
        if (clr_en)
        begin
            valid_next[clr_slot] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_age_reg   <= '0;
            for (int i = 0; i < DEPTH; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[rd_addr];
            rd_age_reg   <= age_reg[rd_addr];
            for (int i = 0; i < DEPTH; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    always_comb
    begin
        free_slot = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;
    assign rd_age   = rd_age_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sorb_minscan.sv =====
// Shared compare unit: walks the store one slot a cycle to find the smallest entry.
`default_nettype none

module sorb_minscan #(
    parameter int DEPTH = 32,
    localparam int SLOT_W = $clog2(DEPTH)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic [SLOT_W-1:0]                  rd_addr,
    input  wire sorb_pkg::entry_t              rd_entry,
    input  wire logic                          rd_valid,
    input  wire logic [sorb_pkg::AGE_W-1:0]    rd_age,
    output logic                               done,
    output logic                               found,
    output logic [SLOT_W-1:0]                  best_slot,
    output sorb_pkg::entry_t                   best_entry
);

    localparam int PTR_W = $clog2(DEPTH + 1);

    logic                              busy_reg;
    logic [PTR_W-1:0]                  ptr_reg;
    logic                              cmp_vld_reg;
    logic                              cmp_last_reg;
    logic [SLOT_W-1:0]                 cmp_slot_reg;
    logic                              found_reg;
    logic                              done_reg;
    logic [SLOT_W-1:0]                 best_slot_reg;
    sorb_pkg::entry_t                  best_entry_reg;
    logic [sorb_pkg::AGE_W-1:0]        best_age_reg;
    logic                              issue;
    logic                              take;

    assign issue = busy_reg && (ptr_reg != PTR_W'(DEPTH));

    assign take = cmp_vld_reg && rd_valid &&
                  (!found_reg ||
                   (rd_entry.index < best_entry_reg.index) ||
                   ((rd_entry.index == best_entry_reg.index) && (rd_age > best_age_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            ptr_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            cmp_last_reg <= 1'b0;
            cmp_slot_reg <= '0;
            found_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg     <= cmp_vld_reg && cmp_last_reg;
            cmp_vld_reg  <= issue;
            cmp_last_reg <= (ptr_reg == PTR_W'(DEPTH - 1));
            cmp_slot_reg <= ptr_reg[SLOT_W-1:0];
            if (start)
            begin
                busy_reg  <= 1'b1;
                ptr_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
                if (cmp_vld_reg && cmp_last_reg)
                begin
                    busy_reg <= 1'b0;
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_slot_reg  <= cmp_slot_reg;
            best_entry_reg <= rd_entry;
            best_age_reg   <= rd_age;
        end
    end

    assign rd_addr    = ptr_reg[SLOT_W-1:0];
    assign done       = done_reg;
    assign found      = found_reg;
    assign best_slot  = best_slot_reg;
    assign best_entry = best_entry_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sorb_seq.sv =====
// Sequencer: evict, insert, release and flush steps plus result staging.
`default_nettype none

module sorb_seq #(
    parameter int DEPTH = 32,
    localparam int SLOT_W = $clog2(DEPTH)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sorb_pkg::cfg_t                cfg,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [63:0]                   s_tdata,
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [95:0]                        m_tdata,
    output logic [sorb_pkg::KIND_W-1:0]        m_tuser,
    output logic                               m_tlast,
    output logic                               scan_start,
    input  wire logic                          scan_done,
    input  wire logic                          scan_found,
    input  wire logic [SLOT_W-1:0]             best_slot,
    input  wire sorb_pkg::entry_t              best_entry,
    input  wire logic [SLOT_W-1:0]             free_slot,
    output logic                               ins_en,
    output logic [SLOT_W-1:0]                  ins_slot,
    output sorb_pkg::entry_t                   ins_entry,
    output logic                               clr_en,
    output logic [SLOT_W-1:0]                  clr_slot
);

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam logic [sorb_pkg::CFG_W-1:0] DEPTH_CFG = sorb_pkg::CFG_W'(DEPTH);

    sorb_pkg::state_t                  state_reg;
    sorb_pkg::state_t                  state_next;
    sorb_pkg::mode_t                   mode_reg;
    sorb_pkg::mode_t                   mode_next;
    sorb_pkg::entry_t                  in_entry_reg;
    logic [OCC_W-1:0]                  occ_reg;
    logic [sorb_pkg::IDX_W-1:0]        exp_reg;
    sorb_pkg::result_t                 res_reg;
    sorb_pkg::result_t                 pend_reg;
    logic                              pend_vld_reg;
    sorb_pkg::result_t                 out_reg;
    logic                              out_last_reg;
    logic                              out_vld_reg;

    logic [sorb_pkg::CFG_W-1:0]        occ_cfg;
    logic [sorb_pkg::CFG_W-1:0]        limit;
    logic                              need_evict;
    logic                              out_free;
    logic                              emit_go;
    logic                              final_go;
    logic                              accept;
    logic                              dec_emit;
    sorb_pkg::result_t                 dec_res;
    logic [sorb_pkg::IDX_W-1:0]        top;
    logic [sorb_pkg::IDX_W-1:0]        top_inc;

    assign occ_cfg    = sorb_pkg::CFG_W'(occ_reg);
    assign limit      = (cfg.depth_limit > DEPTH_CFG) ? DEPTH_CFG : cfg.depth_limit;
    assign need_evict = (occ_reg != '0) && (occ_cfg >= limit);
    assign out_free   = !out_vld_reg || m_tready;
    assign emit_go    = (state_reg == sorb_pkg::ST_EMIT) && (!pend_vld_reg || out_free);
    assign final_go   = (state_reg == sorb_pkg::ST_FINAL) && (!pend_vld_reg || out_free);
    assign accept     = (state_reg == sorb_pkg::ST_IDLE) && s_tvalid;
    assign top        = best_entry.index;
    assign top_inc    = top + 1'b1;

    always_comb
    begin
        dec_emit               = 1'b0;
        dec_res.kind           = sorb_pkg::KIND_EVICT;
        dec_res.index          = best_entry.index;
        dec_res.descriptor     = best_entry.descriptor;
        dec_res.expected_after = exp_reg;
        unique case (mode_reg)
            sorb_pkg::MODE_EVICT:
            begin
                dec_emit = scan_found;
            end
            sorb_pkg::MODE_FLUSH:
            begin
                dec_emit     = scan_found;
                dec_res.kind = sorb_pkg::KIND_FLUSH;
                if (top >= exp_reg)
                begin
                    dec_res.expected_after = top_inc;
                end
            end
            sorb_pkg::MODE_RELEASE:
            begin
                priority if (!scan_found)
                begin
                    dec_emit = 1'b0;
                end
                else if (top == exp_reg)
                begin
                    dec_emit               = 1'b1;
                    dec_res.kind           = sorb_pkg::KIND_IN_ORDER;
                    dec_res.expected_after = top_inc;
                end
                else if (occ_cfg >= cfg.wait_threshold)
                begin
                    dec_emit = 1'b1;
                    if (top < exp_reg)
                    begin
                        dec_res.kind = sorb_pkg::KIND_STALE;
                    end
                    else
                    begin
                        dec_res.kind           = sorb_pkg::KIND_GAP_SKIP;
                        dec_res.expected_after = top_inc;
                    end
                end
                else
                begin
                    dec_emit = 1'b0;
                end
            end
            default:
            begin
                dec_emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        unique case (state_reg)
            sorb_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == sorb_pkg::OP_FLUSH)
                    begin
                        mode_next  = sorb_pkg::MODE_FLUSH;
                        state_next = cfg.release_enable ? sorb_pkg::ST_FIND_START
                                                        : sorb_pkg::ST_IDLE;
                    end
                    else if (need_evict)
                    begin
                        mode_next  = sorb_pkg::MODE_EVICT;
                        state_next = sorb_pkg::ST_FIND_START;
                    end
                    else
                    begin
                        mode_next  = sorb_pkg::MODE_RELEASE;
                        state_next = sorb_pkg::ST_INSERT;
                    end
                end
            end
            sorb_pkg::ST_FIND_START:
            begin
                state_next = sorb_pkg::ST_FIND_WAIT;
            end
            sorb_pkg::ST_FIND_WAIT:
            begin
                if (scan_done)
                begin
                    state_next = sorb_pkg::ST_DECIDE;
                end
            end
            sorb_pkg::ST_DECIDE:
            begin
                state_next = dec_emit ? sorb_pkg::ST_EMIT : sorb_pkg::ST_FINAL;
            end
            sorb_pkg::ST_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = (mode_reg == sorb_pkg::MODE_EVICT) ? sorb_pkg::ST_INSERT
                                                                    : sorb_pkg::ST_FIND_START;
                end
            end
            sorb_pkg::ST_INSERT:
            begin
                mode_next  = sorb_pkg::MODE_RELEASE;
                state_next = cfg.release_enable ? sorb_pkg::ST_FIND_START
                                                : sorb_pkg::ST_FINAL;
            end
            sorb_pkg::ST_FINAL:
            begin
                if (final_go)
                begin
                    state_next = sorb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sorb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = (state_reg == sorb_pkg::ST_IDLE);
        scan_start = (state_reg == sorb_pkg::ST_FIND_START);
        ins_en     = (state_reg == sorb_pkg::ST_INSERT);
        ins_slot   = free_slot;
        ins_entry  = in_entry_reg;
        clr_en     = emit_go;
        clr_slot   = best_slot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sorb_pkg::ST_IDLE;
            mode_reg     <= sorb_pkg::MODE_RELEASE;
            occ_reg      <= '0;
            exp_reg      <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            if (out_vld_reg && m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (emit_go)
            begin
                exp_reg      <= res_reg.expected_after;
                occ_reg      <= occ_reg - 1'b1;
                pend_vld_reg <= 1'b1;
                if (pend_vld_reg)
                begin
                    out_vld_reg  <= 1'b1;
                    out_last_reg <= 1'b0;
                end
            end
            if (state_reg == sorb_pkg::ST_INSERT)
            begin
                occ_reg <= occ_reg + 1'b1;
            end
            if (final_go && pend_vld_reg)
            begin
                pend_vld_reg <= 1'b0;
                out_vld_reg  <= 1'b1;
                out_last_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_entry_reg <= sorb_pkg::entry_t'(s_tdata);
        end
        if (state_reg == sorb_pkg::ST_DECIDE)
        begin
            res_reg <= dec_res;
        end
        if (emit_go)
        begin
            pend_reg <= res_reg;
        end
        if ((emit_go || final_go) && pend_vld_reg)
        begin
            out_reg <= pend_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_reg.expected_after, out_reg.descriptor, out_reg.index};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy above store depth");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sorb_pkg::ST_IDLE) |-> !pend_vld_reg)
        else $error("held result left over at idle");

    a_evict_found: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == sorb_pkg::ST_DECIDE) && (mode_reg == sorb_pkg::MODE_EVICT))
        |-> scan_found)
        else $error("evict scan found no entry");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sorb_pkg::ST_INSERT) |-> (occ_reg < OCC_W'(DEPTH)))
        else $error("insert into full store");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |-> (occ_reg != '0))
        else $error("emit from empty store");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sequence_reorder_buffer.sv =====
// Top level of the sequence reorder buffer: register port, store, scan unit, sequencer.
// Each search for the smallest entry walks the store one slot a cycle.
// One item is worked at a time; the next is taken while the final result waits at the output.
// rst_n is asynchronous: valid bits, ages, occupancy and expected index clear, registers reload.
`default_nettype none

module sequence_reorder_buffer #(
    parameter int STORE_DEPTH = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [sorb_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [sorb_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [sorb_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                     pready,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [63:0]                         s_tdata,   // sequence index, descriptor
    input  wire logic                                s_tuser,   // operation
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [95:0]                              m_tdata,   // out_index, out_descriptor,
                                                                // expected_after
    output logic [sorb_pkg::KIND_W-1:0]              m_tuser,   // kind
    output logic                                     m_tlast
);

    localparam int SLOT_W = $clog2(STORE_DEPTH);

    logic [sorb_pkg::CFG_W-1:0]        depth_limit_reg;
    logic [sorb_pkg::CFG_W-1:0]        wait_threshold_reg;
    logic                              release_enable_reg;
    sorb_pkg::cfg_t                    cfg;
    logic                              cfg_wr;
    logic [1:0]                        reg_sel;

    logic [SLOT_W-1:0]                 rd_addr;
    sorb_pkg::entry_t                  rd_entry;
    logic                              rd_valid;
    logic [sorb_pkg::AGE_W-1:0]        rd_age;
    logic                              ins_en;
    logic [SLOT_W-1:0]                 ins_slot;
    sorb_pkg::entry_t                  ins_entry;
    logic                              clr_en;
    logic [SLOT_W-1:0]                 clr_slot;
    logic [SLOT_W-1:0]                 free_slot;
    logic                              scan_start;
    logic                              scan_done;
    logic                              scan_found;
    logic [SLOT_W-1:0]                 best_slot;
    sorb_pkg::entry_t                  best_entry;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_limit_reg    <= sorb_pkg::DEPTH_LIMIT_RST;
            wait_threshold_reg <= sorb_pkg::WAIT_THRESHOLD_RST;
            release_enable_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                sorb_pkg::REG_DEPTH_LIMIT:    depth_limit_reg    <= pwdata[sorb_pkg::CFG_W-1:0];
                sorb_pkg::REG_WAIT_THRESHOLD: wait_threshold_reg <= pwdata[sorb_pkg::CFG_W-1:0];
                sorb_pkg::REG_RELEASE_ENABLE: release_enable_reg <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            sorb_pkg::REG_DEPTH_LIMIT:    prdata = sorb_pkg::APB_DATA_W'(depth_limit_reg);
            sorb_pkg::REG_WAIT_THRESHOLD: prdata = sorb_pkg::APB_DATA_W'(wait_threshold_reg);
            sorb_pkg::REG_RELEASE_ENABLE: prdata = sorb_pkg::APB_DATA_W'(release_enable_reg);
            default:                      prdata = '0;
        endcase
    end

    assign cfg.depth_limit    = depth_limit_reg;
    assign cfg.wait_threshold = wait_threshold_reg;
    assign cfg.release_enable = release_enable_reg;

    sorb_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (rd_addr),
        .rd_entry  (rd_entry),
        .rd_valid  (rd_valid),
        .rd_age    (rd_age),
        .ins_en    (ins_en),
        .ins_slot  (ins_slot),
        .ins_entry (ins_entry),
        .clr_en    (clr_en),
        .clr_slot  (clr_slot),
        .free_slot (free_slot)
    );

    sorb_minscan #(
        .DEPTH (STORE_DEPTH)
    ) u_minscan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_start),
        .rd_addr    (rd_addr),
        .rd_entry   (rd_entry),
        .rd_valid   (rd_valid),
        .rd_age     (rd_age),
        .done       (scan_done),
        .found      (scan_found),
        .best_slot  (best_slot),
        .best_entry (best_entry)
    );

    sorb_seq #(
        .DEPTH (STORE_DEPTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .scan_start (scan_start),
        .scan_done  (scan_done),
        .scan_found (scan_found),
        .best_slot  (best_slot),
        .best_entry (best_entry),
        .free_slot  (free_slot),
        .ins_en     (ins_en),
        .ins_slot   (ins_slot),
        .ins_entry  (ins_entry),
        .clr_en     (clr_en),
        .clr_slot   (clr_slot)
    );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the sequence reorder buffer: random packet streams, APB setup, scoreboard.

localparam int STORE_SLOTS = 32;

typedef struct {
    logic [sorb_pkg::KIND_W-1:0] kind;
    logic [31:0]                 index;
    logic [31:0]                 descriptor;
    logic [31:0]                 exp_after;
    logic                        last;
} release_t;

class release_tracker;
    sorb_pkg::entry_t slot[STORE_SLOTS];
    bit               used[STORE_SLOTS];
    bit [7:0]         age[STORE_SLOTS];
    int               fill;
    bit [31:0]        next_index;
    bit [5:0]         depth_limit;
    bit [5:0]         wait_threshold;
    bit               release_on;
    release_t         due[$];
    int               errors;

    function new();
        for (int i = 0; i < STORE_SLOTS; i++)
        begin
            used[i] = 1'b0;
            age[i]  = 8'd0;
        end
        fill           = 0;
        next_index     = 32'd0;
        depth_limit    = sorb_pkg::DEPTH_LIMIT_RST;
        wait_threshold = sorb_pkg::WAIT_THRESHOLD_RST;
        release_on     = 1'b0;
        errors         = 0;
    endfunction

    function void set_reg(logic [1:0] which, logic [31:0] value);
        case (which)
            sorb_pkg::REG_DEPTH_LIMIT:    depth_limit    = value[5:0];
            sorb_pkg::REG_WAIT_THRESHOLD: wait_threshold = value[5:0];
            sorb_pkg::REG_RELEASE_ENABLE: release_on     = value[0];
            default: ;
        endcase
    endfunction

    // lowest index wins, oldest first on equal indices
    function int smallest();
        int pick;
        pick = -1;
        for (int i = 0; i < STORE_SLOTS; i++)
        begin
            if (used[i])
            begin
                if (pick < 0 || slot[i].index < slot[pick].index ||
                    (slot[i].index == slot[pick].index && age[i] > age[pick]))
                    pick = i;
            end
        end
        return pick;
    endfunction

    function void emit(logic [sorb_pkg::KIND_W-1:0] kind, int s);
        release_t r;
        r.kind       = kind;
        r.index      = slot[s].index;
        r.descriptor = slot[s].descriptor;
        r.exp_after  = next_index;
        r.last       = 1'b0;
        due.insert(due.size(), r);
        used[s] = 1'b0;
        fill--;
    endfunction

    function void note_item(logic op, logic [31:0] idx, logic [31:0] desc);
        int       first;
        int       s;
        int       limit;
        bit       busy;
        release_t r;
        first = due.size();
        if (op == sorb_pkg::OP_FLUSH)
        begin
            if (release_on)
            begin
                s = smallest();
                while (s >= 0)
                begin
                    if (slot[s].index >= next_index)
                        next_index = slot[s].index + 32'd1;
                    emit(sorb_pkg::KIND_FLUSH, s);
                    s = smallest();
                end
            end
        end
        else
        begin
            limit = (depth_limit > STORE_SLOTS) ? STORE_SLOTS : int'(depth_limit);
            if (fill > 0 && fill >= limit)
            begin
                s = smallest();
                if (s >= 0)
                    emit(sorb_pkg::KIND_EVICT, s);
            end
            for (int i = 0; i < STORE_SLOTS; i++)
                if (used[i] && age[i] != 8'hFF)
                    age[i]++;
            s = -1;
            for (int i = 0; i < STORE_SLOTS; i++)
                if (!used[i] && s < 0)
                    s = i;
            if (s >= 0)
            begin
                slot[s].index      = idx;
                slot[s].descriptor = desc;
                used[s]            = 1'b1;
                age[s]             = 8'd0;
                fill++;
            end
            if (release_on)
            begin
                busy = 1'b1;
                while (busy)
                begin
                    s = smallest();
                    if (s < 0)
                        busy = 1'b0;
                    else if (slot[s].index == next_index)
                    begin
                        next_index = next_index + 32'd1;
                        emit(sorb_pkg::KIND_IN_ORDER, s);
                    end
                    else if (fill >= int'(wait_threshold))
                    begin
                        if (slot[s].index < next_index)
                            emit(sorb_pkg::KIND_STALE, s);
                        else
                        begin
                            next_index = slot[s].index + 32'd1;
                            emit(sorb_pkg::KIND_GAP_SKIP, s);
                        end
                    end
                    else
                        busy = 1'b0;
                end
            end
        end
        if (due.size() > first)
        begin
            r = due.pop_back();
            r.last = 1'b1;
            due.insert(due.size(), r);
        end
    endfunction

    function void check_result(logic [sorb_pkg::KIND_W-1:0] kind, logic [31:0] idx,
                               logic [31:0] desc, logic [31:0] exp_after, logic last);
        release_t want;
        if (due.size() == 0)
        begin
            $error("unexpected beat: kind %0d out_index %0h", kind, idx);
            errors++;
            return;
        end
        want = due.pop_front();
        if (kind !== want.kind)
        begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            errors++;
        end
        if (idx !== want.index)
        begin
            $error("out_index: expected %0h, got %0h", want.index, idx);
            errors++;
        end
        if (desc !== want.descriptor)
        begin
            $error("out_descriptor: expected %0h, got %0h", want.descriptor, desc);
            errors++;
        end
        if (exp_after !== want.exp_after)
        begin
            $error("expected_after: expected %0h, got %0h", want.exp_after, exp_after);
            errors++;
        end
        if (last !== want.last)
        begin
            $error("last: expected %0b, got %0b", want.last, last);
            errors++;
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 2 * (STORE_SLOTS + 5) + 20;
    localparam int RANDOM_ITEMS  = 350;

    logic                             clk      = 1'b0;
    logic                             rst_n    = 1'b0;
    logic                             psel     = 1'b0;
    logic                             penable  = 1'b0;
    logic                             pwrite   = 1'b0;
    logic [sorb_pkg::APB_ADDR_W-1:0]  paddr    = '0;
    logic [sorb_pkg::APB_DATA_W-1:0]  pwdata   = '0;
    logic [sorb_pkg::APB_DATA_W-1:0]  prdata;
    logic                             pready;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [63:0]                      s_tdata  = '0;    // sequence index, descriptor
    logic                             s_tuser  = 1'b0;  // operation
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [95:0]                      m_tdata;          // out_index, out_descriptor,
                                                        // expected_after
    logic [sorb_pkg::KIND_W-1:0]      m_tuser;          // kind
    logic                             m_tlast;

    int send_idle = 27;
    int recv_idle = 65;

    release_tracker tracker = new();

    logic [31:0] burst[$];
    logic [31:0] late[$];
    logic [31:0] gen_base = 32'd0;

    logic [5:0] plan_depth[8]   = '{6'd32, 6'd8, 6'd32, 6'd32, 6'd63, 6'd1, 6'd16, 6'd0};
    logic [5:0] plan_wait[8]    = '{6'd32, 6'd4, 6'd32, 6'd0, 6'd63, 6'd1, 6'd63, 6'd5};
    logic       plan_release[8] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

    sequence_reorder_buffer #(.STORE_DEPTH(STORE_SLOTS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                                 m_tlast);

    task automatic send_item(input logic op, input logic [31:0] idx, input logic [31:0] desc);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {desc, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_item(op, idx, desc);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] which, input logic [5:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= {26'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        tracker.set_reg(which, {26'd0, value});
        @(negedge clk);
    endtask

    task automatic configure(input logic [5:0] depth, input logic [5:0] wait_thr,
                             input logic rel);
        write_reg(sorb_pkg::REG_DEPTH_LIMIT, depth);
        write_reg(sorb_pkg::REG_WAIT_THRESHOLD, wait_thr);
        write_reg(sorb_pkg::REG_RELEASE_ENABLE, {5'd0, rel});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drop valid, drain every pending result, then let a silent item finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tracker.due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [31:0] take_burst_index();
        int          n;
        int          w;
        logic [31:0] t;
        if (burst.size() == 0)
        begin
            if ($signed(gen_base - tracker.next_index) > 40 ||
                $signed(gen_base - tracker.next_index) < -40 || $urandom_range(0, 9) == 0)
                gen_base = tracker.next_index;
            n = $urandom_range(2, 8);
            for (int j = 0; j < n; j++)
                burst.insert(burst.size(), gen_base + 32'(j));
            gen_base = gen_base + n;
            while (late.size() > 0)
            begin
                t = late.pop_front();
                if ($urandom_range(0, 9) < 7)
                    burst.insert(burst.size(), t);
            end
            for (int j = burst.size() - 1; j > 0; j--)
            begin
                w        = $urandom_range(0, j);
                t        = burst[j];
                burst[j] = burst[w];
                burst[w] = t;
            end
            // hold one back to open a gap, sometimes repeat one
            if ($urandom_range(0, 3) == 0)
            begin
                w = $urandom_range(0, burst.size() - 1);
                late.insert(late.size(), burst[w]);
                burst.delete(w);
            end
            if ($urandom_range(0, 9) == 0)
                burst.insert(burst.size(), burst[$urandom_range(0, burst.size() - 1)]);
        end
        return burst.pop_front();
    endfunction

    initial
    begin
        int          done_count;
        int          phase;
        int          span;
        int          r;
        logic        op;
        logic [31:0] idx;
        logic [31:0] desc;
        logic [5:0]  depth;
        logic [5:0]  wait_thr;
        logic        rel;

        done_count = 0;
        phase      = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(sorb_pkg::OP_INSERT, 32'd5, 32'h0000_0000);
        send_item(sorb_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(sorb_pkg::OP_INSERT, 32'd0, 32'hA5A5_A5A5);
        send_item(sorb_pkg::OP_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_idle();
        configure(6'd32, 6'd32, 1'b1);
        send_item(sorb_pkg::OP_INSERT, 32'd1, 32'h5A5A_5A5A);
        send_item(sorb_pkg::OP_INSERT, 32'd2, $urandom);
        send_item(sorb_pkg::OP_INSERT, 32'd3, $urandom);
        send_item(sorb_pkg::OP_INSERT, 32'd3, $urandom);
        send_item(sorb_pkg::OP_FLUSH, 32'd0, 32'd0);
        wait_idle();
        configure(6'd3, 6'd2, 1'b1);
        send_item(sorb_pkg::OP_INSERT, 32'd10, $urandom);
        send_item(sorb_pkg::OP_INSERT, 32'd7, $urandom);
        send_item(sorb_pkg::OP_INSERT, 32'd4, $urandom);
        send_item(sorb_pkg::OP_INSERT, 32'd9, $urandom);
        wait_idle();
        configure(6'd0, 6'd63, 1'b1);
        send_item(sorb_pkg::OP_INSERT, 32'd20, $urandom);
        send_item(sorb_pkg::OP_INSERT, 32'd30, $urandom);
        send_item(sorb_pkg::OP_INSERT, 32'd11, $urandom);
        wait_idle();
        configure(6'd63, 6'd0, 1'b1);
        send_item(sorb_pkg::OP_INSERT, 32'd100, $urandom);
        send_item(sorb_pkg::OP_INSERT, 32'd50, $urandom);
        send_item(sorb_pkg::OP_INSERT, 32'hFFFF_FFFE, $urandom);
        send_item(sorb_pkg::OP_INSERT, 32'hFFFF_FFFF, $urandom);
        send_item(sorb_pkg::OP_FLUSH, $urandom, $urandom);

        while (done_count < RANDOM_ITEMS)
        begin
            wait_idle();
            if (phase < 8)
            begin
                depth    = plan_depth[phase];
                wait_thr = plan_wait[phase];
                rel      = plan_release[phase];
            end
            else
            begin
                depth    = 6'($urandom_range(0, 63));
                wait_thr = 6'($urandom_range(0, 40));
                rel      = ($urandom_range(0, 5) != 0);
            end
            configure(depth, wait_thr, rel);
            span = $urandom_range(25, 50);
            for (int k = 0; k < span && done_count < RANDOM_ITEMS; k++)
            begin
                if (done_count < RANDOM_ITEMS / 3)
                begin
                    send_idle = 27;
                    recv_idle = 65;
                end
                else if (done_count < 2 * RANDOM_ITEMS / 3)
                begin
                    send_idle = 65;
                    recv_idle = 27;
                end
                else
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
                r    = $urandom_range(0, 99);
                op   = sorb_pkg::OP_INSERT;
                desc = $urandom;
                if (r < 6)
                begin
                    op  = sorb_pkg::OP_FLUSH;
                    idx = $urandom;
                end
                else if (r < 70)
                    idx = take_burst_index();
                else if (r < 80)
                    idx = tracker.next_index - $urandom_range(1, 16);
                else if (r < 90)
                    idx = $urandom;
                else if (r < 94)
                    idx = 32'hFFFF_FFFF - $urandom_range(0, 8);
                else
                    idx = tracker.next_index + $urandom_range(1, 40);
                send_item(op, idx, desc);
                if (op == sorb_pkg::OP_INSERT || tracker.release_on)
                    done_count++;
            end
            phase++;
        end

        wait_idle();
        if (tracker.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("status: fail");
        $finish;
    end
endmodule
